// ===== rtl/bpf_pkg.sv =====
package bpf_pkg;

   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int CFG_W  = 9;
   localparam int STS_W  = 2;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [STS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STS_W-1:0] STS_NO_EMPTY = 2'd1;
   localparam logic [STS_W-1:0] STS_NO_FULL  = 2'd2;
   localparam logic [STS_W-1:0] STS_END      = 2'd3;

   localparam logic [CFG_W-1:0] UNIT_BYTES_RESET = 9'd256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

endpackage

// ===== rtl/bpf_store.sv =====
module bpf_store import bpf_pkg::*; #(
   parameter int DEPTH = 2048,
   parameter int ADDRW = 11
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDRW-1:0]  waddr,
   input  logic [BYTE_W-1:0] wdata,
   input  logic [ADDRW-1:0]  raddr,
   output logic [BYTE_W-1:0] rdata
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bpf_queue.sv =====
module bpf_queue import bpf_pkg::*; #(
   parameter int DEPTH    = 8,
   parameter int WIDTH    = 3,
   parameter bit INIT_SEQ = 1'b0
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_ctl_type    ctl,
   input  logic [WIDTH-1:0] push_data,
   output logic [WIDTH-1:0] head_data,
   output logic             is_empty
);

   localparam int PTRW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;
   logic [PTRW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTRW-1:0] next_ptr(input logic [PTRW-1:0] p);
      if (p == PTRW'(DEPTH - 1)) begin
         return '0;
      end
      return p + PTRW'(1);
   endfunction

   // A push into a full queue and a pop from an empty one are ignored.
   assign do_push  = ctl.push && (count_ff != CNTW'(DEPTH));
   assign do_pop   = ctl.pop && (count_ff != '0);
   assign is_empty = (count_ff == '0);

   always_comb begin
      head_in  = do_pop ? next_ptr(head_ff) : head_ff;
      tail_in  = do_push ? next_ptr(tail_ff) : tail_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= INIT_SEQ ? CNTW'(DEPTH) : '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail_ff] <= push_data;
      end
      rd_ff <= mem[head_ff];
   end

   generate
      if (INIT_SEQ) begin : g_init
         // An entry never written holds its own index after reset.
         logic [DEPTH-1:0] seen_ff;
         logic             seen_q_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               seen_ff <= '0;
            end else if (do_push) begin
               seen_ff[tail_ff] <= 1'b1;
            end
         end

         always_ff @(posedge clock) begin
            seen_q_ff <= seen_ff[head_ff];
         end

         assign head_data = seen_q_ff ? rd_ff : WIDTH'(head_ff);
      end else begin : g_plain
         assign head_data = rd_ff;
      end
   endgenerate

endmodule

// ===== rtl/bpf_ctrl.sv =====
module bpf_ctrl import bpf_pkg::*; #(
   parameter int UNITS          = 8,
   parameter int UNIT_MAX_BYTES = 256,
   localparam int UNITW = $clog2(UNITS),
   localparam int LENW  = $clog2(UNIT_MAX_BYTES + 1),
   localparam int FULLW = UNITW + LENW + 1,
   localparam int ADDRW = $clog2(UNITS * UNIT_MAX_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [BYTE_W-1:0] req_data_in,
   output logic              busy,
   output logic              rsp_valid,
   output logic [BYTE_W-1:0] rsp_read_data,
   output logic              rsp_read_valid,
   output logic [STS_W-1:0]  rsp_status,
   input  logic              csr_we,
   input  logic [CFG_W-1:0]  csr_wdata,
   output queue_ctl_type     eq_ctl,
   output logic [UNITW-1:0]  eq_push_unit,
   input  logic [UNITW-1:0]  eq_head_unit,
   input  logic              eq_empty,
   output queue_ctl_type     fq_ctl,
   output logic [FULLW-1:0]  fq_push_entry,
   input  logic [FULLW-1:0]  fq_head_entry,
   input  logic              fq_empty,
   output logic              st_we,
   output logic [ADDRW-1:0]  st_waddr,
   output logic [BYTE_W-1:0] st_wdata,
   output logic [ADDRW-1:0]  st_raddr,
   input  logic [BYTE_W-1:0] st_rdata
);

   localparam int OFFW = (UNIT_MAX_BYTES > 1) ? $clog2(UNIT_MAX_BYTES) : 1;
   localparam logic [ADDRW-1:0] ADDR_STRIDE = ADDRW'(UNIT_MAX_BYTES);

   state_type state_ff, state_in;

   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic [CFG_W-1:0]  ub_ff;

   logic              wv_ff, wv_in;
   logic [UNITW-1:0]  wunit_ff, wunit_in;
   logic [LENW-1:0]   wfill_ff, wfill_in;

   logic              rv_ff, rv_in;
   logic [UNITW-1:0]  runit_ff, runit_in;
   logic [LENW-1:0]   rlen_ff, rlen_in;
   logic              rend_ff, rend_in;
   logic [LENW-1:0]   roff_ff, roff_in;

   logic              pend_full_ff, pend_full_in;
   logic [FULLW-1:0]  pend_fentry_ff, pend_fentry_in;
   logic              pend_empty_ff, pend_empty_in;
   logic [UNITW-1:0]  pend_eunit_ff, pend_eunit_in;

   logic [STS_W-1:0]  sts_ff, sts_in;
   logic              rdv_ff, rdv_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_rdata_ff, rsp_rdata_in;
   logic              rsp_rvalid_ff, rsp_rvalid_in;
   logic [STS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic [LENW-1:0]   size;
   logic              w_pre, w_hold, w_acq, w_ok;
   logic [UNITW-1:0]  cur_wunit;
   logic [LENW-1:0]   cur_wfill, next_wfill;
   logic              r_pre, r_hold, r_acq, r_ok;
   logic [UNITW-1:0]  fq_unit, cur_runit;
   logic [LENW-1:0]   fq_len, cur_rlen, cur_roff, next_roff;
   logic              fq_end, cur_rend;

   function automatic logic [ADDRW-1:0] store_addr(input logic [UNITW-1:0] u,
                                                   input logic [OFFW-1:0]  o);
      return ADDRW'(u) * ADDR_STRIDE + ADDRW'(o);
   endfunction

   // Effective unit size: zero counts as one, oversize is clamped.
   always_comb begin
      if (ub_ff == '0) begin
         size = LENW'(1);
      end else if (32'(ub_ff) > UNIT_MAX_BYTES) begin
         size = LENW'(UNIT_MAX_BYTES);
      end else begin
         size = LENW'(ub_ff);
      end
   end

   // Writer side: retire a unit left full by a lowered size, then take a fresh one.
   assign w_pre      = wv_ff && (wfill_ff >= size);
   assign w_hold     = wv_ff && !w_pre;
   assign w_acq      = !w_hold && !eq_empty;
   assign w_ok       = w_hold || w_acq;
   assign cur_wunit  = w_acq ? eq_head_unit : wunit_ff;
   assign cur_wfill  = w_acq ? '0 : wfill_ff;
   assign next_wfill = cur_wfill + LENW'(1);

   // Reader side: recycle a drained unit, then pull the next full one.
   assign fq_unit   = fq_head_entry[FULLW-1 -: UNITW];
   assign fq_len    = fq_head_entry[LENW:1];
   assign fq_end    = fq_head_entry[0];
   assign r_pre     = rv_ff && (roff_ff >= rlen_ff) && !rend_ff;
   assign r_hold    = rv_ff && !r_pre;
   assign r_acq     = !r_hold && !fq_empty;
   assign r_ok      = r_hold || r_acq;
   assign cur_runit = r_acq ? fq_unit : runit_ff;
   assign cur_rlen  = r_acq ? fq_len : rlen_ff;
   assign cur_rend  = r_acq ? fq_end : rend_ff;
   assign cur_roff  = r_acq ? '0 : roff_ff;
   assign next_roff = cur_roff + LENW'(1);

   assign st_waddr = store_addr(cur_wunit, cur_wfill[OFFW-1:0]);
   assign st_wdata = data_ff;
   assign st_raddr = store_addr(cur_runit, cur_roff[OFFW-1:0]);

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC:   state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin : outputs
      busy           = (state_ff != ST_IDLE);
      cmd_in         = cmd_ff;
      data_in        = data_ff;
      eq_ctl         = '0;
      fq_ctl         = '0;
      eq_push_unit   = runit_ff;
      fq_push_entry  = {wunit_ff, wfill_ff, 1'b0};
      st_we          = 1'b0;
      wv_in          = wv_ff;
      wunit_in       = wunit_ff;
      wfill_in       = wfill_ff;
      rv_in          = rv_ff;
      runit_in       = runit_ff;
      rlen_in        = rlen_ff;
      rend_in        = rend_ff;
      roff_in        = roff_ff;
      pend_full_in   = 1'b0;
      pend_fentry_in = pend_fentry_ff;
      pend_empty_in  = 1'b0;
      pend_eunit_in  = pend_eunit_ff;
      sts_in         = sts_ff;
      rdv_in         = rdv_ff;
      rsp_valid_in   = 1'b0;
      rsp_rdata_in   = rsp_rdata_ff;
      rsp_rvalid_in  = rsp_rvalid_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in  = req_command;
               data_in = req_data_in;
            end
         end

         ST_EXEC: begin
            sts_in = STS_OK;
            rdv_in = 1'b0;
            case (cmd_ff)
               CMD_WRITE, CMD_END: begin
                  fq_ctl.push = w_pre;
                  eq_ctl.pop  = w_acq;
                  if (!w_ok) begin
                     sts_in = STS_NO_EMPTY;
                     wv_in  = 1'b0;
                  end else if (cmd_ff == CMD_WRITE) begin
                     st_we          = 1'b1;
                     wunit_in       = cur_wunit;
                     wfill_in       = next_wfill;
                     wv_in          = (next_wfill < size);
                     pend_full_in   = (next_wfill >= size);
                     pend_fentry_in = {cur_wunit, next_wfill, 1'b0};
                  end else begin
                     wunit_in       = cur_wunit;
                     wfill_in       = '0;
                     wv_in          = 1'b0;
                     pend_full_in   = 1'b1;
                     pend_fentry_in = {cur_wunit, cur_wfill, 1'b1};
                  end
               end

               CMD_READ: begin
                  eq_ctl.push = r_pre;
                  fq_ctl.pop  = r_acq;
                  if (!r_ok) begin
                     sts_in = STS_NO_FULL;
                     rv_in  = 1'b0;
                  end else if (cur_roff < cur_rlen) begin
                     rdv_in        = 1'b1;
                     runit_in      = cur_runit;
                     rlen_in       = cur_rlen;
                     rend_in       = cur_rend;
                     roff_in       = next_roff;
                     pend_empty_in = (next_roff >= cur_rlen) && !cur_rend;
                     pend_eunit_in = cur_runit;
                     rv_in         = !((next_roff >= cur_rlen) && !cur_rend);
                  end else begin
                     sts_in        = STS_END;
                     runit_in      = cur_runit;
                     rlen_in       = '0;
                     rend_in       = 1'b0;
                     roff_in       = '0;
                     rv_in         = 1'b0;
                     pend_empty_in = 1'b1;
                     pend_eunit_in = cur_runit;
                  end
               end

               default: begin
               end
            endcase
         end

         ST_FINISH: begin
            // Second queue write of the request, deferred from the step above.
            fq_ctl.push   = pend_full_ff;
            fq_push_entry = pend_fentry_ff;
            eq_ctl.push   = pend_empty_ff;
            eq_push_unit  = pend_eunit_ff;
            rsp_valid_in  = 1'b1;
            rsp_rdata_in  = rdv_ff ? st_rdata : '0;
            rsp_rvalid_in = rdv_ff;
            rsp_status_in = sts_ff;
         end

         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ub_ff         <= UNIT_BYTES_RESET;
         wv_ff         <= 1'b0;
         rv_ff         <= 1'b0;
         pend_full_ff  <= 1'b0;
         pend_empty_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_we) begin
            ub_ff <= csr_wdata;
         end
         wv_ff         <= wv_in;
         rv_ff         <= rv_in;
         pend_full_ff  <= pend_full_in;
         pend_empty_ff <= pend_empty_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      data_ff        <= data_in;
      wunit_ff       <= wunit_in;
      wfill_ff       <= wfill_in;
      runit_ff       <= runit_in;
      rlen_ff        <= rlen_in;
      rend_ff        <= rend_in;
      roff_ff        <= roff_in;
      pend_fentry_ff <= pend_fentry_in;
      pend_eunit_ff  <= pend_eunit_in;
      sts_ff         <= sts_in;
      rdv_ff         <= rdv_in;
      rsp_rdata_ff   <= rsp_rdata_in;
      rsp_rvalid_ff  <= rsp_rvalid_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_rdata_ff;
   assign rsp_read_valid = rsp_rvalid_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ===== rtl/unit_buffer_pool_fifo_core.sv =====
// Channel        Ports                                      Handshake
// request        start, req_command, req_data_in            taken when start && !busy
// response       rsp_valid, rsp_read_data, rsp_read_valid,  one-cycle strobe, no stall
//                rsp_status
// configuration  csr_we, csr_wdata                          written when csr_we is high
//
// Every request passes through the accept cycle, an execute step that reads the
// queue heads and the byte store and performs the first queue update, and a
// finish step that performs the second queue update and registers the response.
// The response strobe shows in the cycle after that, and a new request may be
// accepted in that same cycle, so requests do not overlap in the block.
// The sequence is set by the registered reads of the queue memories and
// the byte store, and by each queue taking one write per cycle.
// Reset is synchronous and active high; the empty queue comes out of reset
// holding every unit through per-entry written flags, so no clearing pass is
// needed. The receiver cannot stall, so each response is offered exactly once.

module unit_buffer_pool_fifo_core import bpf_pkg::*; #(
   parameter int UNITS          = 8,
   parameter int UNIT_MAX_BYTES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [BYTE_W-1:0] req_data_in,
   output logic              busy,
   output logic              rsp_valid,
   output logic [BYTE_W-1:0] rsp_read_data,
   output logic              rsp_read_valid,
   output logic [STS_W-1:0]  rsp_status,
   input  logic              csr_we,
   input  logic [CFG_W-1:0]  csr_wdata
);

   // A full-queue entry carries the unit number, its byte count and the
   // end-of-stream mark, packed in that order from the top bit down.
   localparam int UNITW = $clog2(UNITS);
   localparam int LENW  = $clog2(UNIT_MAX_BYTES + 1);
   localparam int FULLW = UNITW + LENW + 1;
   localparam int ADDRW = $clog2(UNITS * UNIT_MAX_BYTES);

   queue_ctl_type     eq_ctl, fq_ctl;
   logic [UNITW-1:0]  eq_push_unit, eq_head_unit;
   logic              eq_empty, fq_empty;
   logic [FULLW-1:0]  fq_push_entry, fq_head_entry;
   logic              st_we;
   logic [ADDRW-1:0]  st_waddr, st_raddr;
   logic [BYTE_W-1:0] st_wdata, st_rdata;

   // The control unit holds the writer and reader cursors and sequences each
   // request through its read-modify-write steps.
   bpf_ctrl #(
      .UNITS          (UNITS),
      .UNIT_MAX_BYTES (UNIT_MAX_BYTES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_command    (req_command),
      .req_data_in    (req_data_in),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_read_data  (rsp_read_data),
      .rsp_read_valid (rsp_read_valid),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .eq_ctl         (eq_ctl),
      .eq_push_unit   (eq_push_unit),
      .eq_head_unit   (eq_head_unit),
      .eq_empty       (eq_empty),
      .fq_ctl         (fq_ctl),
      .fq_push_entry  (fq_push_entry),
      .fq_head_entry  (fq_head_entry),
      .fq_empty       (fq_empty),
      .st_we          (st_we),
      .st_waddr       (st_waddr),
      .st_wdata       (st_wdata),
      .st_raddr       (st_raddr),
      .st_rdata       (st_rdata)
   );

   // Queue of free units; starts out holding every unit in ascending order.
   bpf_queue #(
      .DEPTH    (UNITS),
      .WIDTH    (UNITW),
      .INIT_SEQ (1'b1)
   ) u_empty_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (eq_ctl),
      .push_data (eq_push_unit),
      .head_data (eq_head_unit),
      .is_empty  (eq_empty)
   );

   // Queue of filled units waiting for the reader.
   bpf_queue #(
      .DEPTH    (UNITS),
      .WIDTH    (FULLW),
      .INIT_SEQ (1'b0)
   ) u_full_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fq_ctl),
      .push_data (fq_push_entry),
      .head_data (fq_head_entry),
      .is_empty  (fq_empty)
   );

   // Byte storage for all units, one unit after another.
   bpf_store #(
      .DEPTH (UNITS * UNIT_MAX_BYTES),
      .ADDRW (ADDRW)
   ) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

endmodule

// ===== rtl/bpf_checker.sv =====
module bpf_checker import bpf_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [BYTE_W-1:0] rsp_read_data,
   input logic              rsp_read_valid,
   input logic [STS_W-1:0]  rsp_status
);

   // Every accepted request is answered by a response strobe after its finish step.
   a_response_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("response strobe missing three cycles after a request");

   a_idle_on_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("block busy while its response is shown");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_read_valid) |-> (rsp_read_data == '0))
      else $error("read data not zero without a byte");

   a_byte_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_valid) |-> (rsp_status == STS_OK))
      else $error("byte returned with a non-ok status");

endmodule

bind unit_buffer_pool_fifo_core bpf_checker u_bpf_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import bpf_pkg::*;

   localparam int POOL_UNITS    = 8;
   localparam int POOL_UNIT_MAX = 256;
   localparam int STALL_LIMIT   = 1000;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 120;

   // The core ignores this command code; it has no name in the package.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Unit size per random phase, extremes among them: zero counts as one,
   // anything above the unit capacity counts as the capacity.
   localparam logic [CFG_W-1:0] PHASE_UNIT_BYTES [PHASES] = '{
      9'd3, 9'd256, 9'd1, 9'd511, 9'd0, 9'd2, 9'd17, 9'd255, 9'd5, 9'd128, 9'd8, 9'd64
   };

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              read_valid;
      logic [STS_W-1:0]  status;
   } pool_rsp_type;

   typedef struct packed {
      logic [2:0] unit;
      logic [8:0] length;
      logic       last;
   } closed_unit_type;

   typedef enum bit {
      ROW_REQUEST,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [CFG_W-1:0]  csr_value;
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] data;
      logic [3:0]        copies;
      logic              typed;
      pool_rsp_type      want;
   } plan_row_type;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   // Every input of the core starts at a known value.
   logic              start       = 1'b0;
   logic [CMD_W-1:0]  req_command = CMD_WRITE;
   logic [BYTE_W-1:0] req_data_in = '0;
   logic              csr_we      = 1'b0;
   logic [CFG_W-1:0]  csr_wdata   = '0;

   logic              busy;
   logic              rsp_valid;
   logic [BYTE_W-1:0] rsp_read_data;
   logic              rsp_read_valid;
   logic [STS_W-1:0]  rsp_status;

   unit_buffer_pool_fifo_core #(
      .UNITS          (POOL_UNITS),
      .UNIT_MAX_BYTES (POOL_UNIT_MAX)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_command    (req_command),
      .req_data_in    (req_data_in),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_read_data  (rsp_read_data),
      .rsp_read_valid (rsp_read_valid),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Predictor state: a copy of the pool as the core should hold it.
   // ------------------------------------------------------------------
   logic [CFG_W-1:0]  unit_limit_reg = UNIT_BYTES_RESET;
   logic [BYTE_W-1:0] pool_mem [0:POOL_UNITS*POOL_UNIT_MAX-1];

   // Units that are free to be written, oldest first.
   logic [2:0]   free_ring [0:POOL_UNITS-1];
   logic [2:0]   free_rd  = '0;
   logic [2:0]   free_wr  = '0;
   logic [3:0]   free_cnt = 4'd8;

   // Units that were closed by the writer and wait for the reader.
   closed_unit_type closed_ring [0:POOL_UNITS-1];
   logic [2:0]   closed_rd  = '0;
   logic [2:0]   closed_wr  = '0;
   logic [3:0]   closed_cnt = '0;

   logic         wr_held = 1'b0;
   logic [2:0]   wr_unit = '0;
   logic [8:0]   wr_fill = '0;

   logic         rd_held = 1'b0;
   logic [2:0]   rd_unit = '0;
   logic [8:0]   rd_len  = '0;
   logic [8:0]   rd_pos  = '0;
   logic         rd_last = 1'b0;

   // One expected response per accepted request, in acceptance order.
   pool_rsp_type owed_responses [$];
   int unsigned  mismatches   = 0;
   int unsigned  stall_cycles = 0;
   int unsigned  gap_pct      = 0;

   function automatic void free_push(input logic [2:0] unit);
      if (free_cnt >= POOL_UNITS) return;
      free_ring[free_wr] = unit;
      free_wr = free_wr + 3'd1;
      free_cnt = free_cnt + 4'd1;
   endfunction

   function automatic void closed_push(input logic [2:0] unit, input logic [8:0] length,
                                       input logic last);
      if (closed_cnt >= POOL_UNITS) return;
      closed_ring[closed_wr] = '{unit, length, last};
      closed_wr = closed_wr + 3'd1;
      closed_cnt = closed_cnt + 4'd1;
   endfunction

   // The writer must hold a unit before it stores a byte or closes a stream.
   function automatic bit writer_take();
      if (wr_held) return 1'b1;
      if (free_cnt == 0) return 1'b0;
      wr_unit = free_ring[free_rd];
      free_rd = free_rd + 3'd1;
      free_cnt = free_cnt - 4'd1;
      wr_fill = '0;
      wr_held = 1'b1;
      return 1'b1;
   endfunction

   // A writer unit at or past the current unit size is closed without an
   // end mark. This also catches a size that was lowered under a part-filled
   // unit.
   function automatic void retire_at_span(input logic [8:0] span);
      if (wr_held && wr_fill >= span) begin
         closed_push(wr_unit, wr_fill, 1'b0);
         wr_held = 1'b0;
      end
   endfunction

   // Applies one request to the predictor state and returns the response
   // that the core owes for it.
   function automatic pool_rsp_type pool_fifo_response(input logic [CMD_W-1:0]  command,
                                                       input logic [BYTE_W-1:0] data);
      pool_rsp_type    r;
      logic [8:0]      span;
      closed_unit_type head;
      r = '0;
      if (unit_limit_reg == 0) begin
         span = 9'd1;
      end else if (unit_limit_reg > POOL_UNIT_MAX) begin
         span = 9'(POOL_UNIT_MAX);
      end else begin
         span = unit_limit_reg;
      end
      case (command)
         CMD_WRITE: begin
            retire_at_span(span);
            if (!writer_take()) begin
               r.status = STS_NO_EMPTY;
            end else begin
               pool_mem[{wr_unit, wr_fill[7:0]}] = data;
               wr_fill = wr_fill + 9'd1;
               retire_at_span(span);
            end
         end
         CMD_END: begin
            retire_at_span(span);
            if (!writer_take()) begin
               r.status = STS_NO_EMPTY;
            end else begin
               closed_push(wr_unit, wr_fill, 1'b1);
               wr_held = 1'b0;
               wr_fill = '0;
            end
         end
         CMD_READ: begin
            if (rd_held && rd_pos >= rd_len && !rd_last) begin
               free_push(rd_unit);
               rd_held = 1'b0;
            end
            if (!rd_held && closed_cnt != 0) begin
               head = closed_ring[closed_rd];
               closed_rd = closed_rd + 3'd1;
               closed_cnt = closed_cnt - 4'd1;
               rd_unit = head.unit;
               rd_len  = head.length;
               rd_last = head.last;
               rd_pos  = '0;
               rd_held = 1'b1;
            end
            if (!rd_held) begin
               r.status = STS_NO_FULL;
            end else if (rd_pos < rd_len) begin
               r.read_data  = pool_mem[{rd_unit, rd_pos[7:0]}];
               r.read_valid = 1'b1;
               rd_pos = rd_pos + 9'd1;
               if (rd_pos >= rd_len && !rd_last) begin
                  free_push(rd_unit);
                  rd_held = 1'b0;
               end
            end else begin
               // A drained unit with an end mark goes back to the pool and the
               // read reports end of stream instead of a byte.
               free_push(rd_unit);
               rd_held = 1'b0;
               rd_last = 1'b0;
               rd_len  = '0;
               rd_pos  = '0;
               r.status = STS_END;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Directed table rows.
   // ------------------------------------------------------------------
   function automatic plan_row_type plan_op(input logic [CMD_W-1:0] command,
                                            input logic [BYTE_W-1:0] data,
                                            input logic [3:0] copies);
      plan_row_type row;
      row = '0;
      row.kind    = ROW_REQUEST;
      row.command = command;
      row.data    = data;
      row.copies  = copies;
      return row;
   endfunction

   function automatic plan_row_type plan_check(input logic [CMD_W-1:0] command,
                                               input logic [BYTE_W-1:0] data,
                                               input logic [BYTE_W-1:0] read_data,
                                               input logic read_valid,
                                               input logic [STS_W-1:0] status);
      plan_row_type row;
      row = plan_op(command, data, 4'd1);
      row.typed = 1'b1;
      row.want  = '{read_data, read_valid, status};
      return row;
   endfunction

   function automatic plan_row_type plan_csr(input logic [CFG_W-1:0] value);
      plan_row_type row;
      row = '0;
      row.kind      = ROW_CSR;
      row.csr_value = value;
      return row;
   endfunction

   // ------------------------------------------------------------------
   // Driving.
   // ------------------------------------------------------------------

   // Offers one request and waits until the core takes it. The start line is
   // left high on return, so a request that follows at once goes out without
   // a gap; callers that pause lower it themselves.
   task automatic send_request(input logic [CMD_W-1:0]  command,
                               input logic [BYTE_W-1:0] data,
                               input logic              typed,
                               input pool_rsp_type      want);
      pool_rsp_type predicted;
      if ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start       <= 1'b1;
      req_command <= command;
      req_data_in <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
      // The request was taken at this edge. The predictor always runs so that
      // its state keeps step, even where the table gives the response itself.
      predicted = pool_fifo_response(command, data);
      owed_responses.push_back(typed ? want : predicted);
   endtask

   // The unit size is only changed with the core idle: every response in,
   // and nothing in flight.
   task automatic set_unit_bytes(input logic [CFG_W-1:0] value);
      start <= 1'b0;
      do @(posedge clock); while (owed_responses.size() != 0 || busy);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      unit_limit_reg = value;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // Response checking. The core cannot be held off, so every strobe is a
   // response that must match the oldest outstanding expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : response_check
      pool_rsp_type want;
      if (!reset && rsp_valid) begin
         if (owed_responses.size() == 0) begin
            report_mismatch("response with no request outstanding",
                            32'({rsp_read_data, rsp_read_valid, rsp_status}), '0);
         end else begin
            want = owed_responses.pop_front();
            if (rsp_read_data !== want.read_data) begin
               report_mismatch("read_data", 32'(rsp_read_data), 32'(want.read_data));
            end
            if (rsp_read_valid !== want.read_valid) begin
               report_mismatch("read_valid", 32'(rsp_read_valid), 32'(want.read_valid));
            end
            if (rsp_status !== want.status) begin
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            end
         end
      end
   end

   // Watchdog: the run is stuck when neither a request nor a response moves
   // for far longer than the slowest legal gap between them.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------
   initial begin : stimulus
      plan_row_type directed_plan [0:20];
      pool_rsp_type no_rsp;
      int unsigned  burst_len;
      int unsigned  sent;
      int unsigned  pick;
      logic [CMD_W-1:0] cmd;

      no_rsp = '0;
      for (int u = 0; u < POOL_UNITS; u++) begin
         free_ring[u] = 3'(u);
      end

      // With the reset size of 256 nothing in the first rows fills a unit.
      directed_plan = '{
         // Read right after reset: nothing to drain.
         plan_check(CMD_READ,   8'h00, 8'h00, 1'b0, STS_NO_FULL),
         // The unused command code changes nothing and answers all zeros.
         plan_check(CMD_UNUSED, 8'hFF, 8'h00, 1'b0, STS_OK),
         // A two-byte stream with the extreme byte values, read back, then
         // the end of stream seen by the reader.
         plan_op   (CMD_WRITE,  8'h00, 4'd1),
         plan_op   (CMD_WRITE,  8'hFF, 4'd1),
         plan_check(CMD_END,    8'h00, 8'h00, 1'b0, STS_OK),
         plan_check(CMD_READ,   8'h00, 8'h00, 1'b1, STS_OK),
         plan_check(CMD_READ,   8'h00, 8'hFF, 1'b1, STS_OK),
         plan_check(CMD_READ,   8'h00, 8'h00, 1'b0, STS_END),
         // End of stream with no bytes pending closes an empty unit.
         plan_check(CMD_END,    8'h00, 8'h00, 1'b0, STS_OK),
         plan_check(CMD_READ,   8'h00, 8'h00, 1'b0, STS_END),
         // Two bytes in the writer unit, then the size drops to one: the
         // next write first closes that unit with its two bytes.
         plan_op   (CMD_WRITE,  8'h5A, 4'd1),
         plan_op   (CMD_WRITE,  8'hC3, 4'd1),
         plan_csr  (9'd1),
         plan_op   (CMD_WRITE,  8'h11, 4'd1),
         plan_op   (CMD_READ,   8'hFF, 4'd3),
         // A size of zero counts as one: eight writes use up the pool, and
         // both a further byte and an end mark are dropped.
         plan_csr  (9'd0),
         plan_op   (CMD_WRITE,  8'h96, 4'd8),
         plan_check(CMD_WRITE,  8'h24, 8'h00, 1'b0, STS_NO_EMPTY),
         plan_check(CMD_END,    8'h00, 8'h00, 1'b0, STS_NO_EMPTY),
         plan_op   (CMD_READ,   8'h00, 4'd2),
         // Above the unit capacity the size counts as the capacity.
         plan_csr  (9'd511)
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      gap_pct = 20;
      foreach (directed_plan[r]) begin
         if (directed_plan[r].kind == ROW_CSR) begin
            set_unit_bytes(directed_plan[r].csr_value);
         end else begin
            repeat (directed_plan[r].copies) begin
               send_request(directed_plan[r].command, directed_plan[r].data,
                            directed_plan[r].typed, directed_plan[r].want);
            end
         end
      end

      // Random phases. The sender idles in a fifth of the requests first,
      // then in about half, then never.
      for (int p = 0; p < PHASES; p++) begin
         set_unit_bytes(PHASE_UNIT_BYTES[p]);
         gap_pct = (p < 4) ? 20 : (p < 8) ? 48 : 0;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            // Mostly short bursts; now and then a long one, cut short at the
            // end of the phase.
            burst_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 300)
                                                    : $urandom_range(1, 12);
            if (burst_len > PHASE_ITEMS - sent) begin
               burst_len = PHASE_ITEMS - sent;
            end
            if (pick < 40) begin
               // A stream of bytes, closed by an end of stream half of the time.
               repeat (burst_len) begin
                  send_request(CMD_WRITE, BYTE_W'($urandom_range(0, 255)), 1'b0, no_rsp);
               end
               sent += burst_len;
               if ($urandom_range(0, 1) == 1) begin
                  send_request(CMD_END, BYTE_W'($urandom_range(0, 255)), 1'b0, no_rsp);
                  sent++;
               end
            end else if (pick < 80) begin
               repeat (burst_len) begin
                  send_request(CMD_READ, BYTE_W'($urandom_range(0, 255)), 1'b0, no_rsp);
               end
               sent += burst_len;
            end else if (pick < 90) begin
               send_request(CMD_END, BYTE_W'($urandom_range(0, 255)), 1'b0, no_rsp);
               sent++;
            end else begin
               // Noise: any command code, any byte. Requests the core
               // ignores do not count toward the phase.
               repeat ($urandom_range(1, 4)) begin
                  cmd = CMD_W'($urandom_range(0, 3));
                  send_request(cmd, BYTE_W'($urandom_range(0, 255)), 1'b0, no_rsp);
                  if (cmd != CMD_UNUSED) sent++;
               end
            end
         end
      end

      // Drain: every response in, then a further wait on the clock so that a stray
      // extra strobe would still be caught.
      start <= 1'b0;
      while (owed_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && owed_responses.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
